// ----- rtl/lmts_pkg.sv -----
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared constants, types and the glyph table for the LED matrix text scanner.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int NUM_ROWS    = 7;
  localparam int NUM_CHARS   = 5;
  localparam int GLYPH_WIDTH = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int ROW_W       = 25;
  localparam int ROW_IDX_W   = $clog2(NUM_ROWS);
  localparam int CODE_W      = 8;
  localparam int FIRST_CODE  = 42;
  localparam int LAST_CODE   = 58;
  localparam int NUM_GLYPHS  = LAST_CODE - FIRST_CODE + 1;
  localparam int GLYPH_IDX_W = $clog2(NUM_GLYPHS);

  typedef logic [NUM_CHARS-1:0][CODE_W-1:0] char_arr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  localparam logic [7:0] GLYPH_TABLE [NUM_GLYPHS][GLYPH_ROWS] = '{
    '{8'h00, 8'h00, 8'h0A, 8'h04, 8'h0A, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h04, 8'h0E, 8'h04, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h04, 8'h00, 8'h0E, 8'h00, 8'h04, 8'h00},
    '{8'h00, 8'h0E, 8'h0A, 8'h0A, 8'h0A, 8'h0E, 8'h00},
    '{8'h00, 8'h04, 8'h0C, 8'h04, 8'h04, 8'h0E, 8'h00},
    '{8'h00, 8'h0E, 8'h02, 8'h0E, 8'h08, 8'h0E, 8'h00},
    '{8'h00, 8'h0E, 8'h02, 8'h0E, 8'h02, 8'h0E, 8'h00},
    '{8'h00, 8'h0A, 8'h0A, 8'h0E, 8'h02, 8'h02, 8'h00},
    '{8'h00, 8'h0E, 8'h08, 8'h0E, 8'h02, 8'h0E, 8'h00},
    '{8'h00, 8'h0E, 8'h08, 8'h0E, 8'h0A, 8'h0E, 8'h00},
    '{8'h00, 8'h0E, 8'h02, 8'h02, 8'h02, 8'h02, 8'h00},
    '{8'h00, 8'h0E, 8'h0A, 8'h0E, 8'h0A, 8'h0E, 8'h00},
    '{8'h00, 8'h0E, 8'h0A, 8'h0E, 8'h02, 8'h0E, 8'h00},
    '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00}
  };

  // lit pixels of one glyph row, 1 = lit; unknown codes are blank
  function automatic logic [GLYPH_WIDTH-1:0] glyph_bits(
    input logic [CODE_W-1:0]    code,
    input logic [ROW_IDX_W-1:0] row
  );
    logic [GLYPH_IDX_W-1:0] idx;
    logic [7:0]             raw;
    idx = GLYPH_IDX_W'(code - CODE_W'(FIRST_CODE));
    raw = 8'h00;
    if (code >= CODE_W'(FIRST_CODE) && code <= CODE_W'(LAST_CODE) &&
        32'(row) < GLYPH_ROWS) begin
      raw = GLYPH_TABLE[idx][row];
    end
    return raw[GLYPH_WIDTH-1:0];
  endfunction

endpackage

// ----- rtl/lmts_row_gen.sv -----
// ----------------------------------------------------------------------------
// lmts_row_gen
// Builds one active-low display row from the five character codes.
// ----------------------------------------------------------------------------
module lmts_row_gen (
  input  lmts_pkg::char_arr_t            chars,
  input  logic [lmts_pkg::ROW_IDX_W-1:0] row,
  output logic [lmts_pkg::ROW_W-1:0]     bits
);
  import lmts_pkg::*;

  logic [NUM_CHARS*GLYPH_WIDTH-1:0] lit;

  // first character lands in the highest column group
  always_comb begin
    lit = '0;
    for (int pos = 0; pos < NUM_CHARS; pos++) begin
      lit[pos*GLYPH_WIDTH +: GLYPH_WIDTH] = glyph_bits(chars[pos], row);
    end
  end

  assign bits = ~ROW_W'(lit);

endmodule

// ----- rtl/led_matrix_text_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// led_matrix_text_scanner_unit
// Double-buffered 5x7 text display for five characters.
//
// Requests are issued by raising start with operation and char_0..char_4;
// a request is taken at a clock edge where start is high and busy is low.
// A load request (operation 0) renders the five characters into the back
// buffer one row per cycle through a shared row builder, then swaps the
// buffers. It returns nothing and keeps busy high until the seventh row is written.
// A refresh request (operation 1) reads the front buffer one row per cycle
// and presents each row on row_bits/row_number/last for one cycle, marked
// by row_valid. The request moves the state register to the scan state, and
// each row is then read from the front buffer into the registered outputs.
// last marks the seventh row.
// Either request occupies the unit until the row counter reaches the last row,
// so a new request is taken only once the unit is back in idle.
// Results cannot be held off: the receiver must take each row as shown.
// Reset clears both buffers to zero, makes buffer 1 the front buffer and
// returns the unit to idle.
// ----------------------------------------------------------------------------
module led_matrix_text_scanner_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [7:0]                     char_0,
  input  logic [7:0]                     char_1,
  input  logic [7:0]                     char_2,
  input  logic [7:0]                     char_3,
  input  logic [7:0]                     char_4,
  output logic                           row_valid,
  output logic [lmts_pkg::ROW_W-1:0]     row_bits,
  output logic [lmts_pkg::ROW_IDX_W-1:0] row_number,
  output logic                           last
);
  import lmts_pkg::*;

  state_t                 state;
  state_t                 state_next;
  char_arr_t              chars;
  logic [ROW_IDX_W-1:0]   row;
  logic                   front_select;
  logic [ROW_W-1:0]       frame [2][NUM_ROWS];
  logic [ROW_W-1:0]       gen_bits;
  logic                   take;
  logic                   row_end;

  assign take    = start && !busy;
  assign row_end = (row == ROW_IDX_W'(NUM_ROWS - 1));

  lmts_row_gen u_row_gen (
    .chars (chars),
    .row   (row),
    .bits  (gen_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = (op_t'(operation) == OP_REFRESH) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: if (row_end) state_next = ST_IDLE;
      ST_SCAN: if (row_end) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= '0;
      front_select <= 1'b0;
      row_valid    <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          frame[b][r] <= '0;
        end
      end
    end else begin
      row_valid <= 1'b0;
      if (take) begin
        row   <= '0;
        chars <= {char_0, char_1, char_2, char_3, char_4};
      end
      if (state == ST_LOAD) begin
        frame[front_select][row] <= gen_bits;
        row <= row + 1'b1;
        if (row_end) begin
          front_select <= ~front_select;
        end
      end
      if (state == ST_SCAN) begin
        row_valid  <= 1'b1;
        row_bits   <= frame[~front_select][row];
        row_number <= row + 1'b1;
        last       <= row_end;
        row        <= row + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lmts_checker.sv -----
// ----------------------------------------------------------------------------
// lmts_checker
// Port-level checks for the LED matrix text scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lmts_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           operation,
  input logic                           row_valid,
  input logic [lmts_pkg::ROW_IDX_W-1:0] row_number,
  input logic                           last
);
  import lmts_pkg::*;

  // a taken request occupies the unit
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken but unit not busy");

  // a load request shows no rows
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_LOAD |=> !row_valid)
    else $error("row shown after load request");

  // rows other than the final one arrive back to back, numbered up
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    row_valid && !last |=> row_valid &&
      row_number == ROW_IDX_W'($past(row_number) + 1'b1))
    else $error("row sequence broken");

  // final row carries the top row number
  a_last_num: assert property (@(posedge clk) disable iff (rst)
    row_valid && last |-> row_number == ROW_IDX_W'(NUM_ROWS))
    else $error("last flag on wrong row");

  // refresh still in progress keeps the unit busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    row_valid && !last |-> busy)
    else $error("unit idle during refresh");

endmodule

bind led_matrix_text_scanner_unit lmts_checker u_lmts_checker (.*);
